@@ hdl/jss_pkg.sv @@
// jump search sorted table: shared types, constants and sequencer states
// no dependencies; used by jump_search_sorted_table_top
package jss_pkg;

  // default number of table entries
  localparam int DEFAULT_TABLE_DEPTH = 16;

  // most match results reported for one search
  localparam int MAX_RESULTS = 4;

  // width of the position counters, wide enough for a 5-bit entry count plus one block
  localparam int POS_W = 6;

  // width of the block length (square root of at most 31)
  localparam int STEP_W = 3;

  // width of the hit counter (0 to MAX_RESULTS) and of a hit slot index
  localparam int HIT_CNT_W = $clog2(MAX_RESULTS + 1);
  localparam int HIT_IDX_W = $clog2(MAX_RESULTS);

  // reset value of the entry count register
  localparam logic [4:0] ENTRIES_RESET = 5'd16;

  // request actions
  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_SEARCH = 1'b1;

  // input request
  typedef struct packed {
    logic               action;
    logic [3:0]         entry_index;
    logic signed [31:0] key_value;
    logic [15:0]        record_id;
  } jss_req_t;

  // result
  typedef struct packed {
    logic        found;
    logic [3:0]  match_position;
    logic [15:0] match_record;
    logic        last_result;
  } jss_rsp_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQRT,
    ST_JUMP,
    ST_JUMP_CMP,
    ST_SCAN,
    ST_SCAN_CMP,
    ST_EMIT
  } jss_state_t;

endpackage

@@ hdl/jss_ram.sv @@
// generic single-write, single-read ram with registered read data
// depends on nothing; instanced for the key and record stores
module jss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ hdl/jump_search_sorted_table_top.sv @@
// jump search over a sorted key table with record ids: sequencer, stores, result register
// depends on jss_pkg and jss_ram
//
//  channel  | ports                              | direction | moves
//  ---------+------------------------------------+-----------+----------------------------
//  request  | in_valid, in_stall, in_req         | in        | write entry or search key
//  result   | out_valid, out_stall, out_rsp      | out       | one per match, or not found
//  config   | cfg_wr_en, cfg_wr_data             | in        | entries_in_use
//
// the single read port of the stores and the iterative square root set a search's length.
// in_stall is high from a search's acceptance until its last result is loaded into the
// output register; the output register lets the next request in while it waits.
// synchronous active-low reset; the stores are not cleared and need no clearing pass.
module jump_search_sorted_table_top
  import jss_pkg::*;
#(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  jss_req_t in_req,
  output logic     out_valid,
  input  logic     out_stall,
  output jss_rsp_t out_rsp,
  input  logic     cfg_wr_en,
  input  logic [4:0] cfg_wr_data
);

  localparam int ADDR_W = $clog2(TABLE_DEPTH);

  jss_state_t state_r, state_nxt;

  logic [4:0]          entries_r;
  logic [POS_W-1:0]    n_r, n_nxt;
  logic signed [31:0]  key_r, key_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [POS_W-1:0]    sq_r, sq_nxt;
  logic [POS_W-1:0]    start_r, start_nxt;
  logic [POS_W-1:0]    stop_r, stop_nxt;
  logic [HIT_CNT_W-1:0] hit_cnt_r, hit_cnt_nxt;
  logic [HIT_IDX_W-1:0] emit_r, emit_nxt;
  logic [3:0]          hit_pos_r [MAX_RESULTS];
  logic [15:0]         hit_rec_r [MAX_RESULTS];
  logic                hit_wr;

  logic                out_valid_r, out_valid_nxt;
  jss_rsp_t            out_rsp_r, out_rsp_nxt;
  logic                out_free;

  logic                in_acc;
  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;
  logic [POS_W-1:0]    rd_pos;
  logic [ADDR_W-1:0]   rd_addr;
  logic [31:0]         rd_key;
  logic [15:0]         rd_rec;
  logic [POS_W-1:0]    n_req;
  logic [POS_W-1:0]    next_stop;

  // request handshake
  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;

  // table writes; positions beyond the table are dropped
  assign wr_en   = in_acc && (in_req.action == ACT_WRITE) &&
                   (32'(in_req.entry_index) < TABLE_DEPTH);
  assign wr_addr = ADDR_W'(in_req.entry_index);

  // read address: block end while jumping, scan position otherwise
  assign rd_pos  = (state_r == ST_JUMP) ? stop_r : start_r;
  assign rd_addr = ADDR_W'(rd_pos);

  jss_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_key_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_req.key_value),
    .rd_addr (rd_addr),
    .rd_data (rd_key)
  );

  jss_ram #(.WIDTH(16), .DEPTH(TABLE_DEPTH)) u_rec_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_req.record_id),
    .rd_addr (rd_addr),
    .rd_data (rd_rec)
  );

  // entry count clamped to one .. table depth
  always_comb begin
    if (entries_r == 5'd0) begin
      n_req = POS_W'(1);
    end else if (32'(entries_r) > TABLE_DEPTH) begin
      n_req = POS_W'(TABLE_DEPTH);
    end else begin
      n_req = POS_W'(entries_r);
    end
  end

  // next block end, clamped to the entry count
  always_comb begin
    next_stop = stop_r + POS_W'(step_r);
    if (next_stop > n_r - POS_W'(1)) begin
      next_stop = n_r;
    end
  end

  assign out_free = !out_valid_r || !out_stall;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    key_nxt       = key_r;
    step_nxt      = step_r;
    sq_nxt        = sq_r;
    start_nxt     = start_r;
    stop_nxt      = stop_r;
    hit_cnt_nxt   = hit_cnt_r;
    emit_nxt      = emit_r;
    hit_wr        = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    out_rsp_nxt   = out_rsp_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_req.action == ACT_SEARCH)) begin
          n_nxt       = n_req;
          key_nxt     = in_req.key_value;
          step_nxt    = '0;
          sq_nxt      = POS_W'(1);
          hit_cnt_nxt = '0;
          emit_nxt    = '0;
          state_nxt   = ST_SQRT;
        end
      end
      // floor square root by running squares: (r+2)^2 = (r+1)^2 + 2r + 3
      ST_SQRT: begin
        if (sq_r <= n_r) begin
          step_nxt = step_r + STEP_W'(1);
          sq_nxt   = sq_r + POS_W'({step_r, 1'b0}) + POS_W'(3);
        end else begin
          start_nxt = '0;
          stop_nxt  = POS_W'(step_r);
          state_nxt = ST_JUMP;
        end
      end
      // read the block end if it lies below the entry count
      ST_JUMP: begin
        if (stop_r < n_r) begin
          state_nxt = ST_JUMP_CMP;
        end else begin
          state_nxt = ST_SCAN;
        end
      end
      ST_JUMP_CMP: begin
        if ($signed(rd_key) <= key_r) begin
          start_nxt = stop_r;
          stop_nxt  = next_stop;
          state_nxt = ST_JUMP;
        end else begin
          state_nxt = ST_SCAN;
        end
      end
      // scan the block one entry at a time
      ST_SCAN: begin
        if ((start_r < stop_r) && (hit_cnt_r < HIT_CNT_W'(MAX_RESULTS))) begin
          state_nxt = ST_SCAN_CMP;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_SCAN_CMP: begin
        if ($signed(rd_key) == key_r) begin
          hit_wr      = 1'b1;
          hit_cnt_nxt = hit_cnt_r + HIT_CNT_W'(1);
        end
        start_nxt = start_r + POS_W'(1);
        state_nxt = ST_SCAN;
      end
      // hand the hits, or a not-found result, to the output register
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (hit_cnt_r == '0) begin
            out_rsp_nxt = '{found: 1'b0, match_position: 4'd0, match_record: 16'd0,
                            last_result: 1'b1};
            state_nxt   = ST_IDLE;
          end else begin
            out_rsp_nxt.found          = 1'b1;
            out_rsp_nxt.match_position = hit_pos_r[emit_r];
            out_rsp_nxt.match_record   = hit_rec_r[emit_r];
            out_rsp_nxt.last_result    = (HIT_CNT_W'(emit_r) + HIT_CNT_W'(1) == hit_cnt_r);
            if (out_rsp_nxt.last_result) begin
              state_nxt = ST_IDLE;
            end else begin
              emit_nxt = emit_r + HIT_IDX_W'(1);
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      entries_r   <= ENTRIES_RESET;
      hit_cnt_r   <= '0;
      emit_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hit_cnt_r   <= hit_cnt_nxt;
      emit_r      <= emit_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        entries_r <= cfg_wr_data;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    n_r       <= n_nxt;
    key_r     <= key_nxt;
    step_r    <= step_nxt;
    sq_r      <= sq_nxt;
    start_r   <= start_nxt;
    stop_r    <= stop_nxt;
    out_rsp_r <= out_rsp_nxt;
    if (hit_wr) begin
      hit_pos_r[hit_cnt_r[HIT_IDX_W-1:0]] <= start_r[3:0];
      hit_rec_r[hit_cnt_r[HIT_IDX_W-1:0]] <= rd_rec;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  // hit count stays within the result limit
  a_hit_limit: assert property (@(posedge clk) disable iff (!rst_n)
    hit_cnt_r <= HIT_CNT_W'(MAX_RESULTS))
    else $error("hit count above result limit");

  // jumping always advances by a nonzero block
  a_step_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_JUMP || state_r == ST_JUMP_CMP) |-> (step_r != '0))
    else $error("zero block length while jumping");

  // block end never passes the entry count
  a_stop_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_JUMP || state_r == ST_JUMP_CMP || state_r == ST_SCAN ||
     state_r == ST_SCAN_CMP) |-> (stop_r <= n_r))
    else $error("block end beyond entry count");

  // a not-found result is always the only and last one
  a_not_found_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_rsp.found) |-> (out_rsp.last_result && out_rsp.match_record == 16'd0))
    else $error("not-found result not marked last");

  // after a not-found result is loaded, the sequencer returns to idle
  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && out_free && (hit_cnt_r == '0)) |=> (state_r == ST_IDLE))
    else $error("sequencer did not return to idle");

endmodule
